// File: src/ps2_frame_receiver_fifo_defines.svh
// Assertion helpers used by the checker of the PS/2 receiver.
`ifndef PS2_FRAME_RECEIVER_FIFO_DEFINES_SVH
`define PS2_FRAME_RECEIVER_FIFO_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define P2RF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p2rf assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define P2RF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p2rf assertion failed");

// Next-cycle implication that is also checked through reset.
`define P2RF_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("p2rf assertion failed");

`endif

// File: src/p2rf_pkg.sv
package p2rf_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // request codes
  localparam logic [1:0] REQ_EDGE   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  // frame phases
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_DATA   = 2'd1;
  localparam logic [1:0] PHASE_PARITY = 2'd2;
  localparam logic [1:0] PHASE_STOP   = 2'd3;

  localparam logic [3:0] DATA_BITS       = 4'd8;
  localparam logic [7:0] PARITY_ERR_BYTE = 8'hFC;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } push_t;

  typedef struct packed {
    logic             pop_ok;
    logic [CNT_W-1:0] count_nxt;
  } fifo_stat_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

// File: src/ps2_frame_receiver_fifo.sv
// PS/2 device-frame receiver with a 16-entry byte FIFO. Each transaction is
// one sampled falling clock edge, a pop or a status query; one is accepted
// every cycle while the result stage is not stalled, and its result shows on
// the outputs after an input register and a result register. The frame decoder
// and the FIFO pointers update as a transaction leaves the input register,
// and the FIFO read lands directly in the result register. A stalled result
// stage holds the input register, so in_ready follows out_ready with one
// stage of slack.
module ps2_frame_receiver_fifo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic       in_clk_level,
  input  logic       in_data_bit,
  input  logic [4:0] in_wanted_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic       out_byte_valid,
  output logic       out_enough_bytes,
  output logic [4:0] out_fill_count
);
  import p2rf_pkg::*;

  localparam int CMP_W = CNT_W + 5;

  logic       s1_valid_r;
  logic [1:0] req_r;
  logic       clk_lvl_r;
  logic       bit_r;
  logic [4:0] wanted_r;
  logic       s1_adv;
  logic       edge_en;
  logic       pop_req;

  logic       out_valid_r;
  logic       byte_valid_r;
  logic       enough_r, enough_nxt;
  logic [4:0] fill_r, fill_nxt;
  logic [7:0] rd_data_r;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] wanted_ext;

  push_t      push;
  fifo_stat_t stat;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign edge_en  = s1_adv && (req_r == REQ_EDGE) && !clk_lvl_r;
  assign pop_req  = s1_adv && (req_r == REQ_POP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r     <= in_req_type;
      clk_lvl_r <= in_clk_level;
      bit_r     <= in_data_bit;
      wanted_r  <= in_wanted_count;
    end
  end

  p2rf_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_en  (edge_en),
    .data_bit (bit_r),
    .push     (push)
  );

  p2rf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .pop_req   (pop_req),
    .push      (push),
    .stat      (stat),
    .rd_data_r (rd_data_r)
  );

  assign cnt_ext    = {5'b0, stat.count_nxt};
  assign wanted_ext = {{CNT_W{1'b0}}, wanted_r};
  assign enough_nxt = (cnt_ext >= wanted_ext);
  assign fill_nxt   = cnt_ext[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      byte_valid_r <= stat.pop_ok;
      enough_r     <= enough_nxt;
      fill_r       <= fill_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_valid   = byte_valid_r;
  assign out_byte_out     = byte_valid_r ? rd_data_r : 8'h00;
  assign out_enough_bytes = enough_r;
  assign out_fill_count   = fill_r;

endmodule

// File: src/p2rf_frame.sv
module p2rf_frame (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           edge_en,
  input  logic           data_bit,
  output p2rf_pkg::push_t push
);
  import p2rf_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] bits_r, bits_nxt;
  logic [3:0] bits_inc;

  assign bits_inc = bits_r + 4'd1;

  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    push.valid = 1'b0;
    push.data  = shift_r;
    if (edge_en) begin
      case (phase_r)
        PHASE_IDLE: begin
          shift_nxt = '0;
          bits_nxt  = '0;
          if (!data_bit) begin
            phase_nxt = PHASE_DATA;
          end
        end
        PHASE_DATA: begin
          // LSB first: shift in from the top
          shift_nxt = {data_bit, shift_r[7:1]};
          bits_nxt  = bits_inc;
          if (bits_inc >= DATA_BITS) begin
            phase_nxt = PHASE_PARITY;
          end
        end
        PHASE_PARITY: begin
          // odd parity: an even total of ones flags the byte
          if ((^shift_r) == data_bit) begin
            shift_nxt = PARITY_ERR_BYTE;
          end
          phase_nxt = PHASE_STOP;
        end
        default: begin
          push.valid = 1'b1;
          phase_nxt  = PHASE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      shift_r <= '0;
      bits_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
    end
  end

endmodule

// File: src/p2rf_fifo.sv
module p2rf_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 pop_req,
  input  p2rf_pkg::push_t      push,
  output p2rf_pkg::fifo_stat_t stat,
  output logic [7:0]           rd_data_r
);
  import p2rf_pkg::*;

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             empty, full, do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(FIFO_DEPTH));
  // drop the byte when full
  assign do_push = push.valid && !full;
  assign do_pop  = pop_req && !empty;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = next_slot(wr_ptr_r);
      cnt_nxt    = cnt_r + CNT_W'(1);
    end else if (do_pop) begin
      rd_ptr_nxt = next_slot(rd_ptr_r);
      cnt_nxt    = cnt_r - CNT_W'(1);
    end
  end

  assign stat.pop_ok    = do_pop;
  assign stat.count_nxt = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.data;
    end
    if (adv) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

// File: src/p2rf_checker.sv
`include "ps2_frame_receiver_fifo_defines.svh"

module p2rf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_out,
  input logic       out_byte_valid,
  input logic       out_enough_bytes,
  input logic [4:0] out_fill_count
);

  // a failed or missing pop shows a zero byte
  `P2RF_ASSERT_IMP(a_zero_byte, out_valid && !out_byte_valid, out_byte_out == 8'h00)

  // reset empties the result stage
  `P2RF_ASSERT_NXT_ALWAYS(a_reset_clears, !rst_n, !out_valid)

  // a stalled result keeps its count and flags
  `P2RF_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_fill_count) && $stable(out_enough_bytes))

  // an idle pipeline takes a new transaction
  `P2RF_ASSERT_NXT(a_ready_when_idle, !out_valid && !in_valid, in_ready)

endmodule

bind ps2_frame_receiver_fifo p2rf_checker u_p2rf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte_out     (out_byte_out),
  .out_byte_valid   (out_byte_valid),
  .out_enough_bytes (out_enough_bytes),
  .out_fill_count   (out_fill_count)
);

// File: tb/ps2_frame_receiver_fifo_test.sv
module ps2_frame_receiver_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  import p2rf_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int STALL_LIMIT       = 5000;
  localparam int HOLD_OFF_CYCLES   = 200;
  localparam int SETTLE_CYCLES     = 10;
  localparam int ITEMS_PER_PHASE   = 200;

  typedef struct {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       enough_bytes;
    logic [4:0] fill_count;
  } rx_reply_t;

  class rx_byte_tracker;
    logic [1:0] phase;
    logic [7:0] shifter;
    logic [3:0] bits_in;
    logic [7:0] held_bytes[$];
    rx_reply_t  replies[$];
    int         errors;

    function new();
      phase   = PHASE_IDLE;
      shifter = '0;
      bits_in = '0;
      errors  = 0;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    // Advance the frame decoder and FIFO for one accepted transaction.
    function void note_request(logic [1:0] req, logic clk_lvl, logic dbit,
                               logic [4:0] wanted);
      rx_reply_t r;
      r.byte_out   = 8'h00;
      r.byte_valid = 1'b0;
      if (req == REQ_EDGE) begin
        if (!clk_lvl) begin
          case (phase)
            PHASE_IDLE: begin
              shifter = '0;
              bits_in = '0;
              if (!dbit) phase = PHASE_DATA;
            end
            PHASE_DATA: begin
              shifter = {dbit, shifter[7:1]};
              bits_in = bits_in + 4'd1;
              if (bits_in >= DATA_BITS) phase = PHASE_PARITY;
            end
            PHASE_PARITY: begin
              // odd parity: an even total of ones marks the byte bad
              if ((^shifter) == dbit) shifter = PARITY_ERR_BYTE;
              phase = PHASE_STOP;
            end
            default: begin
              if (held_bytes.size() < FIFO_DEPTH) held_bytes.push_back(shifter);
              phase = PHASE_IDLE;
            end
          endcase
        end
      end else if (req == REQ_POP && held_bytes.size() > 0) begin
        r.byte_out   = held_bytes.pop_front();
        r.byte_valid = 1'b1;
      end
      r.fill_count   = 5'(held_bytes.size());
      r.enough_bytes = (held_bytes.size() >= wanted);
      replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [7:0] byte_out, logic byte_valid,
                              logic enough_bytes, logic [4:0] fill_count);
      rx_reply_t want;
      if (replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %0h valid %0b",
                 $time, byte_out, byte_valid);
        errors++;
        return;
      end
      want = replies.pop_front();
      compare_field("byte_out", want.byte_out, byte_out);
      compare_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
      compare_field("enough_bytes", 8'(want.enough_bytes), 8'(enough_bytes));
      compare_field("fill_count", 8'(want.fill_count), 8'(fill_count));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = REQ_STATUS;
  logic       in_clk_level = 1'b0;
  logic       in_data_bit = 1'b0;
  logic [4:0] in_wanted_count = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_out;
  logic       out_byte_valid;
  logic       out_enough_bytes;
  logic [4:0] out_fill_count;

  rx_byte_tracker sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  bit hold_req = 1'b0;

  ps2_frame_receiver_fifo u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_clk_level     (in_clk_level),
    .in_data_bit      (in_data_bit),
    .in_wanted_count  (in_wanted_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_out     (out_byte_out),
    .out_byte_valid   (out_byte_valid),
    .out_enough_bytes (out_enough_bytes),
    .out_fill_count   (out_fill_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(in_req_type, in_clk_level, in_data_bit, in_wanted_count);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_reply(out_byte_out, out_byte_valid, out_enough_bytes, out_fill_count);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ps2_frame_receiver_fifo_test failed");
      $finish;
    end
  end

  // Result side: random back-pressure, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [4:0] rand_wanted();
    return 5'($urandom_range(16));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic send_item(logic [1:0] req, logic clk_lvl, logic dbit, logic [4:0] wanted);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_clk_level    <= clk_lvl;
    in_data_bit     <= dbit;
    in_wanted_count <= wanted;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Glitch edges and status queries slipped between frame edges.
  task automatic side_item();
    case ($urandom_range(3))
      0, 1:    send_item(REQ_EDGE, 1'b1, rand_bit(), rand_wanted());
      2:       send_item(REQ_STATUS, rand_bit(), rand_bit(), rand_wanted());
      default: send_item(REQ_SPARE, rand_bit(), rand_bit(), rand_wanted());
    endcase
  endtask

  task automatic send_frame(logic [7:0] value, bit good_parity, int side_pct);
    logic [10:0] frame_bits;
    logic        parity;
    parity     = good_parity ? ~^value : ^value;
    frame_bits = {rand_bit(), parity, value, 1'b0};
    for (int i = 0; i < 11; i++) begin
      if ($urandom_range(99) < side_pct) side_item();
      send_item(REQ_EDGE, 1'b0, frame_bits[i], rand_wanted());
    end
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_traffic(int count);
    int target;
    int pop_pct;
    int steps;
    int roll;
    target  = items_sent + count;
    pop_pct = 30;
    steps   = 0;
    while (items_sent < target) begin
      // switch between filling and draining bursts
      if (steps % 40 == 0) begin
        case ($urandom_range(2))
          0:       pop_pct = 5;
          1:       pop_pct = 35;
          default: pop_pct = 70;
        endcase
      end
      steps++;
      if ($urandom_range(99) < pop_pct) begin
        send_item(REQ_POP, rand_bit(), rand_bit(), rand_wanted());
      end else begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          send_frame(8'($urandom_range(255)), $urandom_range(99) < 85, 15);
        end else if (roll < 85) begin
          send_item(REQ_EDGE, rand_bit(), rand_bit(), rand_wanted());
        end else if (roll < 92) begin
          // truncated frame: start bit and a few data bits
          send_item(REQ_EDGE, 1'b0, 1'b0, rand_wanted());
          repeat ($urandom_range(1, 8)) send_item(REQ_EDGE, 1'b0, rand_bit(), rand_wanted());
        end else begin
          side_item();
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 79;

    send_item(REQ_STATUS, 1'b1, 1'b1, 5'd16);
    send_item(REQ_SPARE, 1'b0, 1'b1, 5'd0);
    send_item(REQ_POP, 1'b1, 1'b1, 5'd0);
    send_item(REQ_EDGE, 1'b1, 1'b0, 5'd1);
    send_item(REQ_EDGE, 1'b0, 1'b1, 5'd0);
    send_frame(8'hFF, 1'b1, 0);
    send_frame(8'h00, 1'b0, 0);
    send_item(REQ_POP, 1'b0, 1'b0, 5'd1);
    send_item(REQ_POP, 1'b0, 1'b0, 5'd16);

    // overfill, then empty past the last byte
    repeat (FIFO_DEPTH + 2) send_frame(8'($urandom_range(255)), $urandom_range(7) != 0, 20);
    send_item(REQ_STATUS, 1'b0, 1'b0, 5'd16);
    repeat (FIFO_DEPTH + 2) send_item(REQ_POP, rand_bit(), rand_bit(), rand_wanted());
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      run_traffic(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ps2_frame_receiver_fifo_test passed");
    end else begin
      $display("ps2_frame_receiver_fifo_test failed");
    end
    $finish;
  end

endmodule
